// ----- rtl/asw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asw_pkg
// Shared types, constants and fixed-point helpers for the affine subset warp.
// ----------------------------------------------------------------------------
package asw_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned TRIG_W = 18;
    localparam int unsigned IDX_W  = 3;
    localparam int unsigned MASK_W = 3;
    localparam int unsigned WIDE_W = 66;

    // Q16.16 one
    localparam logic signed [DATA_W-1:0] ONE_Q16  = 32'sd65536;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 18'sd65536;

    localparam logic signed [WIDE_W-1:0] SAT_HI = 66'sd2147483647;
    localparam logic signed [WIDE_W-1:0] SAT_LO = -66'sd2147483648;

    // enable mask bit positions
    localparam int unsigned EN_ROT = 0;
    localparam int unsigned EN_STR = 1;
    localparam int unsigned EN_SHR = 2;

    typedef enum logic [IDX_W-1:0] {
        CFG_COS   = 3'd0,
        CFG_SIN   = 3'd1,
        CFG_SXX   = 3'd2,
        CFG_SYY   = 3'd3,
        CFG_SHEAR = 3'd4,
        CFG_DISPX = 3'd5,
        CFG_DISPY = 3'd6,
        CFG_MASK  = 3'd7
    } t_cfg_idx;

    // effective warp parameters, disabled terms already folded in
    typedef struct packed {
        logic signed [TRIG_W-1:0] c;
        logic signed [TRIG_W-1:0] s;
        logic signed [DATA_W-1:0] kx;
        logic signed [DATA_W-1:0] ky;
        logic signed [DATA_W-1:0] gxy;
        logic signed [DATA_W-1:0] ux;
        logic signed [DATA_W-1:0] uy;
        logic                     rot_en;
        logic                     str_en;
        logic                     shr_en;
    } t_cfg;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] cx;
        logic signed [DATA_W-1:0] cy;
        logic signed [DATA_W-1:0] gx;
        logic signed [DATA_W-1:0] gy;
        logic                     rot;
    } t_pix;

    typedef struct packed {
        logic signed [DATA_W-1:0] wx;
        logic signed [DATA_W-1:0] wy;
        logic signed [DATA_W-1:0] tu;
        logic signed [DATA_W-1:0] tv;
        logic signed [DATA_W-1:0] tang;
        logic signed [DATA_W-1:0] tex;
        logic signed [DATA_W-1:0] tey;
        logic signed [DATA_W-1:0] tsh;
    } t_res;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_HI) begin
            r = 32'sh7fffffff;
        end else if (v < SAT_LO) begin
            r = 32'sh80000000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // floor(p / 2^16) of an 18x32 product, widened
    function automatic logic signed [WIDE_W-1:0] qm50(input logic signed [49:0] p);
        return WIDE_W'($signed(p[49:16]));
    endfunction

    // floor(p / 2^16) of a 32x32 product, widened
    function automatic logic signed [WIDE_W-1:0] qm64(input logic signed [63:0] p);
        return WIDE_W'($signed(p[63:16]));
    endfunction

    function automatic logic signed [WIDE_W-1:0] wd(input logic signed [DATA_W-1:0] v);
        return WIDE_W'(v);
    endfunction

endpackage
`default_nettype wire

// ----- rtl/affine_subset_warp_and_gradient_terms.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// affine_subset_warp_and_gradient_terms
// Q16.16 affine warp of one subset pixel plus its six Gauss-Newton terms.
// ----------------------------------------------------------------------------
// The block takes one pixel transaction per clock and returns one result per
// clock while its output is not stalled. Each result passes through the seven
// register stages, each of which holds multiplier products, add-and-saturate
// results or both (the first stage loads at the edge that accepts its pixel).
// A stalled output holds only the unbroken run of full stages behind it, so
// the input keeps accepting while any stage is empty.
// Configuration registers are written through a plain write port and must
// only change while no transaction is in flight.
module affine_subset_warp_and_gradient_terms (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [asw_pkg::IDX_W-1:0]           i_cfg_idx,
    input  wire logic [asw_pkg::DATA_W-1:0]          i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   i_px,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   i_py,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   i_centre_x,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   i_centre_y,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   i_grad_x,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   i_grad_y,
    input  wire logic                                i_rotate_grads,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [asw_pkg::DATA_W-1:0]        o_warped_x,
    output logic signed [asw_pkg::DATA_W-1:0]        o_warped_y,
    output logic signed [asw_pkg::DATA_W-1:0]        o_term_u,
    output logic signed [asw_pkg::DATA_W-1:0]        o_term_v,
    output logic signed [asw_pkg::DATA_W-1:0]        o_term_angle,
    output logic signed [asw_pkg::DATA_W-1:0]        o_term_ex,
    output logic signed [asw_pkg::DATA_W-1:0]        o_term_ey,
    output logic signed [asw_pkg::DATA_W-1:0]        o_term_shear
);

    asw_pkg::t_cfg w_cfg;
    asw_pkg::t_pix w_pix;
    asw_pkg::t_res w_res;
    logic          w_pipe_rdy;

    asw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    always_comb begin
        w_pix.px  = i_px;
        w_pix.py  = i_py;
        w_pix.cx  = i_centre_x;
        w_pix.cy  = i_centre_y;
        w_pix.gx  = i_grad_x;
        w_pix.gy  = i_grad_y;
        w_pix.rot = i_rotate_grads;
    end

    asw_pipe u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (i_in_valid && i_rst_n),
        .o_ready (w_pipe_rdy),
        .i_pix   (w_pix),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_res   (w_res)
    );

    // take no transaction while reset is held
    assign o_in_ready   = w_pipe_rdy && i_rst_n;

    assign o_warped_x   = w_res.wx;
    assign o_warped_y   = w_res.wy;
    assign o_term_u     = w_res.tu;
    assign o_term_v     = w_res.tv;
    assign o_term_angle = w_res.tang;
    assign o_term_ex    = w_res.tex;
    assign o_term_ey    = w_res.tey;
    assign o_term_shear = w_res.tsh;

endmodule
`default_nettype wire

// ----- rtl/asw_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asw_cfg
// Configuration registers and the effective warp parameters derived from them.
// ----------------------------------------------------------------------------
module asw_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [asw_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [asw_pkg::DATA_W-1:0]  i_cfg_data,
    output asw_pkg::t_cfg                    o_cfg
);

    logic signed [asw_pkg::TRIG_W-1:0] r_cos;
    logic signed [asw_pkg::TRIG_W-1:0] r_sin;
    logic signed [asw_pkg::DATA_W-1:0] r_sxx;
    logic signed [asw_pkg::DATA_W-1:0] r_syy;
    logic signed [asw_pkg::DATA_W-1:0] r_shr;
    logic signed [asw_pkg::DATA_W-1:0] r_ux;
    logic signed [asw_pkg::DATA_W-1:0] r_uy;
    logic [asw_pkg::MASK_W-1:0]        r_mask;

    logic w_rot;
    logic w_str;
    logic w_shr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos  <= asw_pkg::TRIG_ONE;
            r_sin  <= '0;
            r_sxx  <= '0;
            r_syy  <= '0;
            r_shr  <= '0;
            r_ux   <= '0;
            r_uy   <= '0;
            r_mask <= '1;
        end else if (i_cfg_we) begin
            unique case (asw_pkg::t_cfg_idx'(i_cfg_idx))
                asw_pkg::CFG_COS:   r_cos  <= i_cfg_data[asw_pkg::TRIG_W-1:0];
                asw_pkg::CFG_SIN:   r_sin  <= i_cfg_data[asw_pkg::TRIG_W-1:0];
                asw_pkg::CFG_SXX:   r_sxx  <= i_cfg_data;
                asw_pkg::CFG_SYY:   r_syy  <= i_cfg_data;
                asw_pkg::CFG_SHEAR: r_shr  <= i_cfg_data;
                asw_pkg::CFG_DISPX: r_ux   <= i_cfg_data;
                asw_pkg::CFG_DISPY: r_uy   <= i_cfg_data;
                asw_pkg::CFG_MASK:  r_mask <= i_cfg_data[asw_pkg::MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_rot = r_mask[asw_pkg::EN_ROT];
    assign w_str = r_mask[asw_pkg::EN_STR];
    assign w_shr = r_mask[asw_pkg::EN_SHR];

    // disabled parameters read as identity / zero
    always_comb begin
        o_cfg.c      = w_rot ? r_cos : asw_pkg::TRIG_ONE;
        o_cfg.s      = w_rot ? r_sin : '0;
        o_cfg.kx     = asw_pkg::sat32(asw_pkg::wd(asw_pkg::ONE_Q16)
                                      + asw_pkg::wd(w_str ? r_sxx : '0));
        o_cfg.ky     = asw_pkg::sat32(asw_pkg::wd(asw_pkg::ONE_Q16)
                                      + asw_pkg::wd(w_str ? r_syy : '0));
        o_cfg.gxy    = w_shr ? r_shr : '0;
        o_cfg.ux     = r_ux;
        o_cfg.uy     = r_uy;
        o_cfg.rot_en = w_rot;
        o_cfg.str_en = w_str;
        o_cfg.shr_en = w_shr;
    end

endmodule
`default_nettype wire

// ----- rtl/asw_pipe.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asw_pipe
// Seven-stage warp and gradient-term datapath; each stage stalls only when
// it holds a transaction that the next stage cannot take.
// ----------------------------------------------------------------------------
module asw_pipe (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire asw_pkg::t_cfg i_cfg,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire asw_pkg::t_pix i_pix,
    output logic        o_valid,
    input  wire logic   i_ready,
    output asw_pkg::t_res o_res
);

    localparam int unsigned NSTG = 7;

    logic [NSTG:1] r_v;
    logic [NSTG:1] w_rdy;

    // stage 1
    logic signed [31:0] r1_dx, r1_dy, r1_cx, r1_cy, r1_gx, r1_gy;
    logic               r1_rot;
    logic signed [49:0] r1_pcgx, r1_psgy, r1_psgx, r1_pcgy;
    // stage 2
    logic signed [31:0] r2_dx, r2_dy, r2_cx, r2_cy, r2_gx, r2_gy;
    logic signed [63:0] r2_pkxdx, r2_pgdy, r2_pkydy, r2_pgdx;
    logic signed [49:0] r2_pcdy, r2_psdx, r2_psdy, r2_pcdx;
    // stage 3
    logic signed [31:0] r3_dx, r3_dy, r3_cx, r3_cy, r3_gx, r3_gy;
    logic signed [31:0] r3_wdx, r3_wdy, r3_sha, r3_shb;
    logic signed [49:0] r3_pgxc, r3_pgys, r3_pgyc, r3_pgxs;
    // stage 4
    logic signed [31:0] r4_dx, r4_dy, r4_cx, r4_cy, r4_gx, r4_gy, r4_ex, r4_ey;
    logic signed [49:0] r4_pcwx, r4_pswy, r4_pswx, r4_pcwy;
    logic signed [63:0] r4_pgxa, r4_pgyb;
    // stage 5
    logic signed [31:0] r5_gx, r5_gy, r5_wx, r5_wy, r5_anga, r5_angb, r5_tsh;
    logic signed [63:0] r5_pexdx, r5_peydy;
    // stage 6
    logic signed [31:0] r6_gx, r6_gy, r6_wx, r6_wy, r6_tsh, r6_tex, r6_tey;
    logic signed [63:0] r6_pga, r6_pgb;
    // stage 7 (output)
    asw_pkg::t_res r7_res;

    // walk from the output back so each stage sees the one after it
    always_comb begin
        w_rdy[NSTG] = !r_v[NSTG] || i_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[1];
    assign o_valid = r_v[NSTG];
    assign o_res   = r7_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_v[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 1: offsets from centre, gradient rotation products
    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_dx   <= asw_pkg::sat32(asw_pkg::wd(i_pix.px) - asw_pkg::wd(i_pix.cx));
            r1_dy   <= asw_pkg::sat32(asw_pkg::wd(i_pix.py) - asw_pkg::wd(i_pix.cy));
            r1_cx   <= i_pix.cx;
            r1_cy   <= i_pix.cy;
            r1_gx   <= i_pix.gx;
            r1_gy   <= i_pix.gy;
            r1_rot  <= i_pix.rot;
            r1_pcgx <= i_cfg.c * i_pix.gx;
            r1_psgy <= i_cfg.s * i_pix.gy;
            r1_psgx <= i_cfg.s * i_pix.gx;
            r1_pcgy <= i_cfg.c * i_pix.gy;
        end
    end

    // stage 2: effective gradients, stretch/shear and shear-term products
    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_gx    <= r1_rot ? asw_pkg::sat32(asw_pkg::qm50(r1_pcgx) - asw_pkg::qm50(r1_psgy))
                               : r1_gx;
            r2_gy    <= r1_rot ? asw_pkg::sat32(asw_pkg::qm50(r1_psgx) + asw_pkg::qm50(r1_pcgy))
                               : r1_gy;
            r2_dx    <= r1_dx;
            r2_dy    <= r1_dy;
            r2_cx    <= r1_cx;
            r2_cy    <= r1_cy;
            r2_pkxdx <= i_cfg.kx * r1_dx;
            r2_pgdy  <= i_cfg.gxy * r1_dy;
            r2_pkydy <= i_cfg.ky * r1_dy;
            r2_pgdx  <= i_cfg.gxy * r1_dx;
            r2_pcdy  <= i_cfg.c * r1_dy;
            r2_psdx  <= i_cfg.s * r1_dx;
            r2_psdy  <= i_cfg.s * r1_dy;
            r2_pcdx  <= i_cfg.c * r1_dx;
        end
    end

    // stage 3: deformed offsets, shear directions, stretch-term products
    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r3_wdx  <= asw_pkg::sat32(asw_pkg::qm64(r2_pkxdx) + asw_pkg::qm64(r2_pgdy));
            r3_wdy  <= asw_pkg::sat32(asw_pkg::qm64(r2_pkydy) + asw_pkg::qm64(r2_pgdx));
            r3_sha  <= asw_pkg::sat32(asw_pkg::qm50(r2_pcdy) - asw_pkg::qm50(r2_psdx));
            r3_shb  <= asw_pkg::sat32(asw_pkg::qm50(r2_psdy) + asw_pkg::qm50(r2_pcdx));
            r3_dx   <= r2_dx;
            r3_dy   <= r2_dy;
            r3_cx   <= r2_cx;
            r3_cy   <= r2_cy;
            r3_gx   <= r2_gx;
            r3_gy   <= r2_gy;
            r3_pgxc <= i_cfg.c * r2_gx;
            r3_pgys <= i_cfg.s * r2_gy;
            r3_pgyc <= i_cfg.c * r2_gy;
            r3_pgxs <= i_cfg.s * r2_gx;
        end
    end

    // stage 4: rotation products, shear-term products, stretch directions
    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r4_pcwx <= i_cfg.c * r3_wdx;
            r4_pswy <= i_cfg.s * r3_wdy;
            r4_pswx <= i_cfg.s * r3_wdx;
            r4_pcwy <= i_cfg.c * r3_wdy;
            r4_pgxa <= r3_gx * r3_sha;
            r4_pgyb <= r3_gy * r3_shb;
            r4_ex   <= asw_pkg::sat32(asw_pkg::qm50(r3_pgxc) + asw_pkg::qm50(r3_pgys));
            r4_ey   <= asw_pkg::sat32(asw_pkg::qm50(r3_pgyc) - asw_pkg::qm50(r3_pgxs));
            r4_dx   <= r3_dx;
            r4_dy   <= r3_dy;
            r4_cx   <= r3_cx;
            r4_cy   <= r3_cy;
            r4_gx   <= r3_gx;
            r4_gy   <= r3_gy;
        end
    end

    // stage 5: warped position, rotation directions, shear term, stretch-term products
    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r5_wx    <= asw_pkg::sat32(asw_pkg::qm50(r4_pcwx) - asw_pkg::qm50(r4_pswy)
                                       + asw_pkg::wd(i_cfg.ux) + asw_pkg::wd(r4_cx));
            r5_wy    <= asw_pkg::sat32(asw_pkg::qm50(r4_pswx) + asw_pkg::qm50(r4_pcwy)
                                       + asw_pkg::wd(i_cfg.uy) + asw_pkg::wd(r4_cy));
            r5_anga  <= asw_pkg::sat32(-asw_pkg::qm50(r4_pswx) - asw_pkg::qm50(r4_pcwy));
            r5_angb  <= asw_pkg::sat32(asw_pkg::qm50(r4_pcwx) - asw_pkg::qm50(r4_pswy));
            r5_tsh   <= i_cfg.shr_en
                        ? asw_pkg::sat32(asw_pkg::qm64(r4_pgxa) + asw_pkg::qm64(r4_pgyb))
                        : '0;
            r5_pexdx <= r4_ex * r4_dx;
            r5_peydy <= r4_ey * r4_dy;
            r5_gx    <= r4_gx;
            r5_gy    <= r4_gy;
        end
    end

    // stage 6: rotation-term products, stretch terms
    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r6_pga <= r5_gx * r5_anga;
            r6_pgb <= r5_gy * r5_angb;
            r6_tex <= i_cfg.str_en ? asw_pkg::sat32(asw_pkg::qm64(r5_pexdx)) : '0;
            r6_tey <= i_cfg.str_en ? asw_pkg::sat32(asw_pkg::qm64(r5_peydy)) : '0;
            r6_gx  <= r5_gx;
            r6_gy  <= r5_gy;
            r6_wx  <= r5_wx;
            r6_wy  <= r5_wy;
            r6_tsh <= r5_tsh;
        end
    end

    // stage 7: rotation term, hold result until taken
    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            r7_res.tang <= i_cfg.rot_en
                           ? asw_pkg::sat32(asw_pkg::qm64(r6_pga) + asw_pkg::qm64(r6_pgb))
                           : '0;
            r7_res.wx   <= r6_wx;
            r7_res.wy   <= r6_wy;
            r7_res.tu   <= r6_gx;
            r7_res.tv   <= r6_gy;
            r7_res.tex  <= r6_tex;
            r7_res.tey  <= r6_tey;
            r7_res.tsh  <= r6_tsh;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/asw_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// asw_checker
// Port-level checks on the affine subset warp, bound to the top level.
// ----------------------------------------------------------------------------
module asw_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                o_in_ready,
    input  wire logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   o_warped_x,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   o_warped_y,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   o_term_u,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   o_term_v,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   o_term_angle,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   o_term_ex,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   o_term_ey,
    input  wire logic signed [asw_pkg::DATA_W-1:0]   o_term_shear
);

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // an empty output stage means every stage can advance
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with an empty output stage");

    // a result being taken frees the whole chain
    a_take_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |-> o_in_ready)
        else $error("input stalled while the result is taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_warped_x) && $stable(o_warped_y)
             && $stable(o_term_u) && $stable(o_term_v) && $stable(o_term_angle)
             && $stable(o_term_ex) && $stable(o_term_ey) && $stable(o_term_shear)))
        else $error("stalled result changed");

endmodule

bind affine_subset_warp_and_gradient_terms asw_checker u_asw_checker (.*);
`default_nettype wire
